FILE: src/pls_pkg.sv
// Package for the proximity LED show controller: types, constants and helpers.
`default_nettype none
package pls_pkg;

  // Number of steps in the scanner sweep
  localparam int SCAN_STEPS_DEF = 6;

  // Register reset values
  localparam logic [10:0] BLINK_TICKS_RST = 11'd102;
  localparam logic [13:0] LOW_LIMIT_RST   = 14'h1ff8;

  // Dwell counts selected by the dip switches, highest switch first
  localparam logic [10:0] DWELL_SW3 = 11'd1221;
  localparam logic [10:0] DWELL_SW2 = 11'd916;
  localparam logic [10:0] DWELL_SW1 = 11'd610;
  localparam logic [10:0] DWELL_SW0 = 11'd305;

  // LED bits driven by the battery check and the blink show
  localparam logic [3:0] LED_LOWBAT = 4'h1;
  localparam logic [3:0] LED_HEART  = 4'h2;
  localparam logic [3:0] LED_ALL    = 4'hf;

  // Configuration register index
  typedef enum logic [1:0] {
    CFG_BLINK_TICKS = 2'd0,
    CFG_LOW_LIMIT   = 2'd1
  } cfg_index_t;

  // Controller mode, also reported as mode_code
  typedef enum logic [2:0] {
    MODE_SENSING = 3'd0,
    MODE_SCANNER = 3'd1,
    MODE_BLINK   = 3'd2,
    MODE_CHECK   = 3'd3,
    MODE_REARM   = 3'd4
  } mode_t;

  // What the tick does to the LEDs
  typedef enum logic [1:0] {
    SHOW_NOTHING   = 2'd0,
    SHOW_SCANNER   = 2'd1,
    SHOW_BLINK     = 2'd2,
    SHOW_HANDS_OFF = 2'd3
  } show_t;

  // Battery check phase
  typedef enum logic [1:0] {
    CHK_START   = 2'd0,
    CHK_MEASURE = 2'd1,
    CHK_SETTLE  = 2'd2,
    CHK_FINISH  = 2'd3
  } check_phase_t;

  // Dwell count from the first set switch, searched from the top
  function automatic logic [10:0] dwell_from_switches(input logic [3:0] sw);
    logic [10:0] d;
    if (sw[3])      d = DWELL_SW3;
    else if (sw[2]) d = DWELL_SW2;
    else if (sw[1]) d = DWELL_SW1;
    else if (sw[0]) d = DWELL_SW0;
    else            d = 11'd0;
    return d;
  endfunction

  // Scanner pattern; the six-entry table repeats for longer sweeps
  function automatic logic [3:0] scan_leds(input logic [3:0] step);
    logic [3:0] l;
    case (step)
      4'd0, 4'd6, 4'd12:        l = 4'h8;
      4'd1, 4'd7, 4'd13:        l = 4'h4;
      4'd2, 4'd8, 4'd14:        l = 4'h2;
      4'd3, 4'd9, 4'd15:        l = 4'h1;
      4'd4, 4'd10:              l = 4'h2;
      default:                  l = 4'h4;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

FILE: src/pls_if.sv
// Channel interfaces: event input, result output and register write.
`default_nettype none
interface pls_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        scan_done;
  logic        presence;
  logic [3:0]  dip_switches;
  logic        minute_event;
  logic        sampler_idle;
  logic [13:0] battery_sum;

  modport source (output valid, kind, scan_done, presence, dip_switches,
                  minute_event, sampler_idle, battery_sum, input ready);
  modport sink (input valid, kind, scan_done, presence, dip_switches,
                minute_event, sampler_idle, battery_sum, output ready);
endinterface

interface pls_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_bits;
  logic       reference_on;
  logic       ticking;
  logic [2:0] mode_code;
  logic       low_battery;
  logic       restart_sensing;

  modport source (output valid, led_bits, reference_on, ticking, mode_code,
                  low_battery, restart_sensing, input ready);
  modport sink (input valid, led_bits, reference_on, ticking, mode_code,
                low_battery, restart_sensing, output ready);
endinterface

interface pls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/proximity_led_show_controller_top.sv
// Proximity LED show controller: event decoder, show state and result register.
//
// Usage: every input word is a timer tick (kind 0) or a main-loop poll
// (kind 1). Each accepted word yields exactly one result word that carries
// the LED nibble, reference enable, timer state, mode, sticky low-battery
// flag and the restart-sensing pulse as they stand after that event.
// Registers are written over the cfg channel (index 0 blink_ticks, index 1
// battery_low_limit); the channel is always ready, unknown indexes are
// dropped. Write only while no result is pending.
// Latency: the result word is valid the cycle after the input word is
// accepted. Throughput: one word per cycle while the receiver takes each
// result, set by the single result register that the next-state logic feeds.
// Stall: while a result sits unread the input stays ready only if the
// receiver takes that result in the same cycle; otherwise input waits.
// Reset (rst, synchronous): mode re-arm, nothing shown, LEDs off, counters
// and flags clear, registers back to 102 and 0x1ff8, no result pending.
`default_nettype none
module proximity_led_show_controller_top #(
  parameter int SCAN_STEPS = pls_pkg::SCAN_STEPS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  pls_in_if.sink       in_ch,
  pls_out_if.source    out_ch,
  pls_cfg_if.sink      cfg_ch
);

  localparam int SCAN_W = (SCAN_STEPS > 2) ? $clog2(SCAN_STEPS) : 1;
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_STEPS - 1);

  // Configuration registers
  logic [10:0] blink_ticks;
  logic [13:0] battery_low_limit;

  // Controller state
  pls_pkg::mode_t        mode, mode_next;
  pls_pkg::show_t        show, show_next;
  logic [10:0]           dwell_left, dwell_left_next;
  logic                  check_timer, check_timer_next;
  pls_pkg::check_phase_t check_phase, check_phase_next;
  logic [SCAN_W-1:0]     scan_step, scan_step_next;
  logic                  blink_phase, blink_phase_next;
  logic [3:0]            leds, leds_next;
  logic                  battery_flag, battery_flag_next;
  logic                  timer_on, timer_on_next;
  logic                  ref_on, ref_on_next;
  logic                  restart_next;

  // Result register
  logic               out_valid;
  logic               restart;

  logic in_fire;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_ticks       <= pls_pkg::BLINK_TICKS_RST;
      battery_low_limit <= pls_pkg::LOW_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pls_pkg::CFG_BLINK_TICKS: blink_ticks       <= cfg_ch.data[10:0];
        pls_pkg::CFG_LOW_LIMIT:   battery_low_limit <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Next state for one tick or poll
  always_comb begin
    mode_next         = mode;
    show_next         = show;
    dwell_left_next   = dwell_left;
    check_timer_next  = check_timer;
    check_phase_next  = check_phase;
    scan_step_next    = scan_step;
    blink_phase_next  = blink_phase;
    leds_next         = leds;
    battery_flag_next = battery_flag;
    timer_on_next     = timer_on;
    ref_on_next       = ref_on;
    restart_next      = 1'b0;

    if (!in_ch.kind) begin
      // Tick: only while the timer runs
      if (timer_on) begin
        unique case (show)
          pls_pkg::SHOW_SCANNER: begin
            leds_next      = pls_pkg::scan_leds(4'(scan_step));
            scan_step_next = (scan_step == SCAN_LAST) ? '0 : scan_step + 1'b1;
          end
          pls_pkg::SHOW_BLINK: begin
            leds_next        = blink_phase ? pls_pkg::LED_ALL : 4'h0;
            blink_phase_next = !blink_phase;
          end
          pls_pkg::SHOW_HANDS_OFF: ;
          default: leds_next = 4'h0;
        endcase
        if (dwell_left != 11'd0) dwell_left_next = dwell_left - 11'd1;
        check_timer_next = 1'b0;
      end
    end else begin
      // Poll: minute event first, then the mode acts
      if (in_ch.minute_event) begin
        mode_next     = pls_pkg::MODE_CHECK;
        show_next     = pls_pkg::SHOW_NOTHING;
        leds_next     = 4'h0;
        timer_on_next = 1'b1;
      end
      unique case (mode_next)
        pls_pkg::MODE_SENSING: begin
          if (in_ch.scan_done) begin
            if (in_ch.presence) begin
              timer_on_next   = 1'b1;
              show_next       = pls_pkg::SHOW_SCANNER;
              mode_next       = pls_pkg::MODE_SCANNER;
              dwell_left_next = pls_pkg::dwell_from_switches(in_ch.dip_switches);
            end else begin
              leds_next = 4'h0;
            end
          end
        end
        pls_pkg::MODE_SCANNER: begin
          if (dwell_left == 11'd0) begin
            mode_next       = pls_pkg::MODE_BLINK;
            dwell_left_next = blink_ticks;
            show_next       = pls_pkg::SHOW_BLINK;
          end
        end
        pls_pkg::MODE_BLINK: begin
          if (dwell_left == 11'd0) begin
            mode_next = pls_pkg::MODE_REARM;
            show_next = pls_pkg::SHOW_NOTHING;
            leds_next = 4'h0;
          end
        end
        pls_pkg::MODE_CHECK: begin
          if (in_ch.sampler_idle) begin
            restart_next = 1'b1;
            // Battery check sequencer
            unique case (check_phase)
              pls_pkg::CHK_START: begin
                show_next = pls_pkg::SHOW_HANDS_OFF;
                leds_next = leds_next | pls_pkg::LED_HEART;
                if (battery_flag) begin
                  leds_next        = leds_next | pls_pkg::LED_LOWBAT;
                  check_phase_next = pls_pkg::CHK_SETTLE;
                end else begin
                  ref_on_next      = 1'b1;
                  check_phase_next = pls_pkg::CHK_MEASURE;
                end
                check_timer_next = 1'b1;
              end
              pls_pkg::CHK_MEASURE: begin
                if (!check_timer) begin
                  if (in_ch.battery_sum >= battery_low_limit) battery_flag_next = 1'b1;
                  leds_next = leds_next & ~(pls_pkg::LED_LOWBAT | pls_pkg::LED_HEART);
                  check_timer_next = 1'b1;
                  check_phase_next = pls_pkg::CHK_SETTLE;
                end
              end
              pls_pkg::CHK_SETTLE: begin
                if (!check_timer) begin
                  check_phase_next = pls_pkg::CHK_FINISH;
                  check_timer_next = 1'b1;
                  ref_on_next      = 1'b0;
                end
              end
              default: begin
                // Finish
                if (!check_timer) begin
                  check_phase_next = pls_pkg::CHK_START;
                  mode_next        = pls_pkg::MODE_REARM;
                  show_next        = pls_pkg::SHOW_NOTHING;
                  leds_next        = 4'h0;
                end
              end
            endcase
          end
        end
        default: begin
          // Re-arm
          timer_on_next = 1'b0;
          restart_next  = 1'b1;
          mode_next     = pls_pkg::MODE_SENSING;
        end
      endcase
    end
  end

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= pls_pkg::MODE_REARM;
      show         <= pls_pkg::SHOW_NOTHING;
      dwell_left   <= '0;
      check_timer  <= 1'b0;
      check_phase  <= pls_pkg::CHK_START;
      scan_step    <= '0;
      blink_phase  <= 1'b0;
      leds         <= '0;
      battery_flag <= 1'b0;
      timer_on     <= 1'b0;
      ref_on       <= 1'b0;
    end else if (in_fire) begin
      mode         <= mode_next;
      show         <= show_next;
      dwell_left   <= dwell_left_next;
      check_timer  <= check_timer_next;
      check_phase  <= check_phase_next;
      scan_step    <= scan_step_next;
      blink_phase  <= blink_phase_next;
      leds         <= leds_next;
      battery_flag <= battery_flag_next;
      timer_on     <= timer_on_next;
      ref_on       <= ref_on_next;
    end
  end

  // Result word valid flag and restart pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b0;
    end else if (in_fire) begin
      restart <= restart_next;
    end
  end

  // Result fields follow the state captured with the word
  assign out_ch.valid           = out_valid;
  assign out_ch.led_bits        = leds;
  assign out_ch.reference_on    = ref_on;
  assign out_ch.ticking         = timer_on;
  assign out_ch.mode_code       = mode;
  assign out_ch.low_battery     = battery_flag;
  assign out_ch.restart_sensing = restart;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the show controller: directed and random events checked against a predictor.
module tb_top;

  localparam int SWEEP_LEN      = pls_pkg::SCAN_STEPS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // Register indexes past the list, dropped by the block
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic        kind;
    logic        scan_done;
    logic        presence;
    logic [3:0]  dip;
    logic        minute;
    logic        sampler_idle;
    logic [13:0] bat_sum;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

  typedef struct packed {
    logic [3:0] led_bits;
    logic       reference_on;
    logic       ticking;
    logic [2:0] mode_code;
    logic       low_battery;
    logic       restart_sensing;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  pls_in_if  ev_ch();
  pls_out_if res_ch();
  pls_cfg_if reg_ch();

  proximity_led_show_controller_top #(.SCAN_STEPS(SWEEP_LEN)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (ev_ch),
    .out_ch (res_ch),
    .cfg_ch (reg_ch)
  );

  always #5 clk = ~clk;

  // Predicted controller state and register copies
  pls_pkg::mode_t        mdl_mode;
  pls_pkg::show_t        mdl_show;
  logic [10:0]           dwell_cnt;
  logic                  chk_timer;
  pls_pkg::check_phase_t chk_phase;
  int                    scan_pos;
  logic                  blink_on;
  logic [3:0]            led_state;
  logic                  bat_low;
  logic                  timer_run;
  logic                  vref_on;
  logic [10:0]           blink_len;
  logic [13:0]           low_limit;

  result_t pending_results[$];
  int      mismatch_count = 0;
  bit      quiet = 1'b0;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Sweep LEDs for a position; the six-entry sweep repeats
  function automatic logic [3:0] sweep_leds(int pos);
    logic [3:0] l;
    case (pos % 6)
      0: l = 4'h8;
      1: l = 4'h4;
      2: l = 4'h2;
      3: l = 4'h1;
      4: l = 4'h2;
      default: l = 4'h4;
    endcase
    return l;
  endfunction

  // Highest set switch wins
  function automatic logic [10:0] switch_dwell(logic [3:0] sw);
    logic [10:0] d;
    casez (sw)
      4'b1???: d = pls_pkg::DWELL_SW3;
      4'b01??: d = pls_pkg::DWELL_SW2;
      4'b001?: d = pls_pkg::DWELL_SW1;
      4'b0001: d = pls_pkg::DWELL_SW0;
      default: d = 11'd0;
    endcase
    return d;
  endfunction

  task automatic reset_show_model();
    mdl_mode  = pls_pkg::MODE_REARM;
    mdl_show  = pls_pkg::SHOW_NOTHING;
    dwell_cnt = '0;
    chk_timer = 1'b0;
    chk_phase = pls_pkg::CHK_START;
    scan_pos  = 0;
    blink_on  = 1'b0;
    led_state = '0;
    bat_low   = 1'b0;
    timer_run = 1'b0;
    vref_on   = 1'b0;
    blink_len = pls_pkg::BLINK_TICKS_RST;
    low_limit = pls_pkg::LOW_LIMIT_RST;
  endtask

  // One step of the battery check
  task automatic battery_step(logic [13:0] bat_sum);
    case (chk_phase)
      pls_pkg::CHK_START: begin
        mdl_show  = pls_pkg::SHOW_HANDS_OFF;
        led_state = led_state | pls_pkg::LED_HEART;
        if (bat_low) begin
          led_state = led_state | pls_pkg::LED_LOWBAT;
          chk_phase = pls_pkg::CHK_SETTLE;
        end else begin
          vref_on   = 1'b1;
          chk_phase = pls_pkg::CHK_MEASURE;
        end
        chk_timer = 1'b1;
      end
      pls_pkg::CHK_MEASURE: if (!chk_timer) begin
        if (bat_sum >= low_limit) bat_low = 1'b1;
        led_state = led_state & ~(pls_pkg::LED_LOWBAT | pls_pkg::LED_HEART);
        chk_timer = 1'b1;
        chk_phase = pls_pkg::CHK_SETTLE;
      end
      pls_pkg::CHK_SETTLE: if (!chk_timer) begin
        chk_phase = pls_pkg::CHK_FINISH;
        chk_timer = 1'b1;
        vref_on   = 1'b0;
      end
      default: if (!chk_timer) begin
        chk_phase = pls_pkg::CHK_START;
        mdl_mode  = pls_pkg::MODE_REARM;
        mdl_show  = pls_pkg::SHOW_NOTHING;
        led_state = '0;
      end
    endcase
  endtask

  // Advance the predicted controller by one event and give its result word
  task automatic advance_show(event_t e, output result_t r);
    logic restart;
    restart = 1'b0;
    if (e.kind == KIND_TICK) begin
      if (timer_run) begin
        case (mdl_show)
          pls_pkg::SHOW_SCANNER: begin
            led_state = sweep_leds(scan_pos);
            scan_pos++;
            if (scan_pos >= SWEEP_LEN) scan_pos = 0;
          end
          pls_pkg::SHOW_BLINK: begin
            led_state = blink_on ? pls_pkg::LED_ALL : 4'h0;
            blink_on  = !blink_on;
          end
          pls_pkg::SHOW_HANDS_OFF: ;
          default: led_state = '0;
        endcase
        if (dwell_cnt != 0) dwell_cnt--;
        chk_timer = 1'b0;
      end
    end else begin
      if (e.minute) begin
        mdl_mode  = pls_pkg::MODE_CHECK;
        mdl_show  = pls_pkg::SHOW_NOTHING;
        led_state = '0;
        timer_run = 1'b1;
      end
      case (mdl_mode)
        pls_pkg::MODE_SENSING: if (e.scan_done) begin
          if (e.presence) begin
            timer_run = 1'b1;
            mdl_show  = pls_pkg::SHOW_SCANNER;
            mdl_mode  = pls_pkg::MODE_SCANNER;
            dwell_cnt = switch_dwell(e.dip);
          end else begin
            led_state = '0;
          end
        end
        pls_pkg::MODE_SCANNER: if (dwell_cnt == 0) begin
          mdl_mode  = pls_pkg::MODE_BLINK;
          dwell_cnt = blink_len;
          mdl_show  = pls_pkg::SHOW_BLINK;
        end
        pls_pkg::MODE_BLINK: if (dwell_cnt == 0) begin
          mdl_mode  = pls_pkg::MODE_REARM;
          mdl_show  = pls_pkg::SHOW_NOTHING;
          led_state = '0;
        end
        pls_pkg::MODE_CHECK: if (e.sampler_idle) begin
          battery_step(e.bat_sum);
          restart = 1'b1;
        end
        default: begin
          timer_run = 1'b0;
          restart   = 1'b1;
          mdl_mode  = pls_pkg::MODE_SENSING;
        end
      endcase
    end
    r.led_bits        = led_state;
    r.reference_on    = vref_on;
    r.ticking         = timer_run;
    r.mode_code       = mdl_mode;
    r.low_battery     = bat_low;
    r.restart_sensing = restart;
  endtask

  // Sender idle gap: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Send one event word, predict its result on acceptance
  task automatic send_event(event_t e);
    result_t r;
    int gap;
    ev_ch.valid        <= 1'b1;
    ev_ch.kind         <= e.kind;
    ev_ch.scan_done    <= e.scan_done;
    ev_ch.presence     <= e.presence;
    ev_ch.dip_switches <= e.dip;
    ev_ch.minute_event <= e.minute;
    ev_ch.sampler_idle <= e.sampler_idle;
    ev_ch.battery_sum  <= e.bat_sum;
    do @(posedge clk); while (!(ev_ch.valid && ev_ch.ready));
    advance_show(e, r);
    pending_results.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic drain();
    ev_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    drain();
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk); while (!(reg_ch.valid && reg_ch.ready));
    case (idx)
      pls_pkg::CFG_BLINK_TICKS: blink_len = val[10:0];
      pls_pkg::CFG_LOW_LIMIT:   low_limit = val;
      default: ;
    endcase
    reg_ch.valid <= 1'b0;
  endtask

  function automatic event_t make_poll(logic scan_done, logic presence, logic [3:0] dip,
                                       logic minute, logic sampler_idle,
                                       logic [13:0] bat_sum);
    event_t e;
    e.kind         = KIND_POLL;
    e.scan_done    = scan_done;
    e.presence     = presence;
    e.dip          = dip;
    e.minute       = minute;
    e.sampler_idle = sampler_idle;
    e.bat_sum      = bat_sum;
    return e;
  endfunction

  // Tick with random don't-care fields
  function automatic event_t make_tick();
    event_t e;
    e = event_t'(EVENT_W'($urandom));
    e.kind = KIND_TICK;
    return e;
  endfunction

  // Random event shaped by the predicted mode so that shows run to the end
  function automatic event_t rand_event(bit noisy);
    event_t e;
    e.kind         = KIND_POLL;
    e.scan_done    = $urandom_range(0, 99) < 70;
    e.presence     = 1'($urandom_range(0, 1));
    e.dip          = ($urandom_range(0, 99) < 97) ? 4'd0 : 4'($urandom_range(1, 15));
    e.sampler_idle = $urandom_range(0, 99) < 80;
    if (noisy) e.bat_sum = 14'($urandom_range(0, 16383));
    else if (low_limit != 0) e.bat_sum = 14'($urandom_range(0, int'(low_limit) - 1));
    else e.bat_sum = '0;
    if ((mdl_mode == pls_pkg::MODE_SCANNER || mdl_mode == pls_pkg::MODE_BLINK) &&
        dwell_cnt > 8) begin
      e.minute = $urandom_range(0, 99) < 2;
      if ($urandom_range(0, 99) < 90) e.kind = KIND_TICK;
    end else begin
      e.minute = $urandom_range(0, 99) < 4;
      if (!timer_run) begin
        if ($urandom_range(0, 99) < 8) e.kind = KIND_TICK;
      end else if ($urandom_range(0, 1) == 0) begin
        e.kind = KIND_TICK;
      end
    end
    return e;
  endfunction

  // Full battery check from a minute event until the block re-arms
  task automatic run_check(logic [13:0] bat_sum);
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b1, 1'b1, bat_sum));
    while (mdl_mode == pls_pkg::MODE_CHECK) begin
      send_event(make_tick());
      send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b1, bat_sum));
    end
  endtask

  task automatic run_random_phase(logic [13:0] blink_val, logic [13:0] limit_val,
                                  int n_items, bit noisy);
    event_t e;
    int done;
    bit counted;
    write_reg(pls_pkg::CFG_BLINK_TICKS, blink_val);
    write_reg(pls_pkg::CFG_LOW_LIMIT, limit_val);
    done = 0;
    while (done < n_items) begin
      quiet = ((done / 100) % 4) == 3;
      e = rand_event(noisy);
      counted = !(e.kind == KIND_TICK && !timer_run);
      send_event(e);
      if (counted) begin
        done++;
        if (done % 120 == 0) drain();
      end
    end
    quiet = 1'b0;
  endtask

  // Scanner, blink and re-arm with a short blink; ticks before the timer runs
  task automatic test_show_cycle();
    write_reg(pls_pkg::CFG_BLINK_TICKS, 14'd2);
    send_event(make_tick());
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 14'h0));
    send_event(make_poll(1'b1, 1'b0, 4'hf, 1'b0, 1'b1, 14'h0));
    send_event(make_poll(1'b0, 1'b1, 4'hf, 1'b0, 1'b0, 14'h0));
    send_event(make_poll(1'b1, 1'b1, 4'h0, 1'b0, 1'b0, 14'h3fff));
    send_event(make_tick());
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 14'h0));
    repeat (2) begin
      send_event(make_tick());
      send_event(make_poll(1'b1, 1'b1, 4'hf, 1'b0, 1'b1, 14'h0));
    end
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 14'h0));
  endtask

  // Battery check just under the limit, sampler busy, minute event mid-check
  task automatic test_battery_check();
    write_reg(pls_pkg::CFG_LOW_LIMIT, pls_pkg::LOW_LIMIT_RST);
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b1, 1'b0, 14'h0));
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b1, 14'h0));
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b1, pls_pkg::LOW_LIMIT_RST - 14'd1));
    send_event(make_tick());
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b1, pls_pkg::LOW_LIMIT_RST - 14'd1));
    send_event(make_poll(1'b1, 1'b1, 4'h8, 1'b1, 1'b1, 14'h0));
    send_event(make_tick());
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b1, 14'h0));
    send_event(make_tick());
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b1, 14'h0));
    send_event(make_poll(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 14'h0));
  endtask

  task automatic test_random_traffic();
    run_random_phase(14'd5, pls_pkg::LOW_LIMIT_RST, 400, 1'b0);
    run_random_phase(14'd0, 14'd16380, 400, 1'b0);
    run_random_phase(14'h3fff, 14'd1, 300, 1'b0);
  endtask

  // Sum at the top of its range sets the sticky flag; later checks skip measuring
  task automatic test_low_battery();
    write_reg(CFG_SPARE_2, 14'h3fff);
    write_reg(CFG_SPARE_3, 14'h0);
    write_reg(pls_pkg::CFG_LOW_LIMIT, 14'h3fff);
    run_check(14'h3ffe);
    run_check(14'h3fff);
    write_reg(pls_pkg::CFG_LOW_LIMIT, 14'h0);
    run_check(14'h0);
  endtask

  task automatic test_random_flagged();
    run_random_phase(14'd1, 14'd0, 300, 1'b1);
  endtask

  // Result checker and receiver stalls
  initial begin
    result_t want;
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("led_bits", res_ch.led_bits, want.led_bits);
          check_field("reference_on", res_ch.reference_on, want.reference_on);
          check_field("ticking", res_ch.ticking, want.ticking);
          check_field("mode_code", res_ch.mode_code, want.mode_code);
          check_field("low_battery", res_ch.low_battery, want.low_battery);
          check_field("restart_sensing", res_ch.restart_sensing, want.restart_sensing);
        end
      end
      if (quiet) begin
        res_ch.ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        case ($urandom_range(0, 24))
          0, 1, 2, 3, 4: stall_left = $urandom_range(1, 3);
          5: stall_left = $urandom_range(8, 40);
          default: ;
        endcase
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst                = 1'b1;
    ev_ch.valid        = 1'b0;
    ev_ch.kind         = KIND_TICK;
    ev_ch.scan_done    = 1'b0;
    ev_ch.presence     = 1'b0;
    ev_ch.dip_switches = 4'h0;
    ev_ch.minute_event = 1'b0;
    ev_ch.sampler_idle = 1'b0;
    ev_ch.battery_sum  = 14'h0;
    reg_ch.valid       = 1'b0;
    reg_ch.index       = pls_pkg::CFG_BLINK_TICKS;
    reg_ch.data        = 14'h0;
    reset_show_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_show_cycle();
    test_battery_check();
    test_random_traffic();
    test_low_battery();
    test_random_flagged();

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/pls_pkg.sv
src/pls_if.sv
src/proximity_led_show_controller_top.sv
tb/sv/tb_top.sv
